// File: hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Holds queue sizing, action and status codes, and the controller/datapath structs.
// No dependencies.
package spq_pkg;

  // Queue sizing and field widths
  localparam int DEPTH          = 16;
  localparam int PAYLOAD_WIDTH  = 32;
  localparam int PRIORITY_WIDTH = 16;
  localparam int CNT_W          = $clog2(DEPTH + 1);

  // Port field widths (fixed by the interface)
  localparam int IN_PAY_W  = 32;
  localparam int IN_PRI_W  = 16;
  localparam int OUT_PAY_W = 32;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 5;

  // Action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic                do_insert;
    logic                do_remove;
    logic                load;
    logic [STATUS_W-1:0] status;
  } spq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
  } spq_stat_t;

endpackage

// File: hw/rtl/spq_ctrl.sv
// Controller for the sorted priority queue: handshake and command generation.
// Tracks whether the result register holds an untaken word.
// Depends on spq_pkg.
module spq_ctrl
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      in_action,
  output logic      out_valid,
  input  logic      out_stall,
  input  spq_stat_t stat,
  output spq_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SHOW = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;
  logic is_insert;

  // Stall only while a result is held and not taken
  assign in_stall  = (state_r == ST_SHOW) && out_stall;
  assign out_valid = (state_r == ST_SHOW);
  assign accept    = in_valid && !in_stall;
  assign is_insert = (in_action == ACT_INSERT);

  // Commands to the cell row
  always_comb begin
    cmd.load      = accept;
    cmd.do_insert = accept && is_insert && !stat.full;
    cmd.do_remove = accept && !is_insert && !stat.empty;
    case (in_action)
      ACT_INSERT: cmd.status = stat.full ? STATUS_FULL : STATUS_OK;
      ACT_REMOVE: cmd.status = stat.empty ? STATUS_EMPTY : STATUS_OK;
      default:    cmd.status = STATUS_OK;
    endcase
  end

  // Result register occupancy
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_SHOW;
      ST_SHOW: begin
        if (accept) state_nxt = ST_SHOW;
        else if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // An accepted word always shows a result next cycle
  a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted word did not produce a result");

  // Insert and remove commands are exclusive
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.do_insert && cmd.do_remove))
    else $error("insert and remove issued together");

  // A stalled result word stays offered
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result word dropped");

endmodule

// File: hw/rtl/spq_datapath.sv
// Datapath for the sorted priority queue: a row of compare-and-shift cells,
// the entry count and the result register. Depends on spq_pkg.
module spq_datapath
  import spq_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  spq_cmd_t                    cmd,
  input  logic [IN_PAY_W-1:0]         in_payload,
  input  logic signed [IN_PRI_W-1:0]  in_priority_req,
  output spq_stat_t                   stat,
  output logic [OUT_PAY_W-1:0]        out_removed_payload,
  output logic [STATUS_W-1:0]         out_status,
  output logic [OCC_W-1:0]            out_occupancy
);

  logic [PAYLOAD_WIDTH-1:0]         pay_r   [DEPTH];
  logic [PAYLOAD_WIDTH-1:0]         pay_nxt [DEPTH];
  logic signed [PRIORITY_WIDTH-1:0] pri_r   [DEPTH];
  logic signed [PRIORITY_WIDTH-1:0] pri_nxt [DEPTH];
  logic [DEPTH-1:0]                 gt;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic [OUT_PAY_W-1:0] res_pay_r;
  logic [OUT_PAY_W-1:0] res_pay_nxt;
  logic [STATUS_W-1:0]  res_status_r;
  logic [OCC_W-1:0]     res_occ_r;

  logic [PAYLOAD_WIDTH-1:0]         new_pay;
  logic signed [PRIORITY_WIDTH-1:0] new_pri;

  // Incoming entry, fitted to stored widths (port and stored widths are equal)
  assign new_pay = PAYLOAD_WIDTH'(in_payload);
  assign new_pri = PRIORITY_WIDTH'(in_priority_req);

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);

  // Cell row: each cell keeps, takes the new entry, shifts down or shifts up
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [PAYLOAD_WIDTH-1:0]         up_pay;
    logic signed [PRIORITY_WIDTH-1:0] up_pri;
    logic [PAYLOAD_WIDTH-1:0]         dn_pay;
    logic signed [PRIORITY_WIDTH-1:0] dn_pri;
    logic                             gt_prev;

    // Stored entry outranks the new one
    assign gt[i] = (CNT_W'(i) < count_r) && (pri_r[i] > new_pri);

    if (i == 0) begin : g_first
      assign up_pay  = new_pay;
      assign up_pri  = new_pri;
      assign gt_prev = 1'b1;
    end else begin : g_rest
      assign up_pay  = pay_r[i-1];
      assign up_pri  = pri_r[i-1];
      assign gt_prev = gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign dn_pay = pay_r[i];
      assign dn_pri = pri_r[i];
    end else begin : g_inner
      assign dn_pay = pay_r[i+1];
      assign dn_pri = pri_r[i+1];
    end

    always_comb begin
      pay_nxt[i] = pay_r[i];
      pri_nxt[i] = pri_r[i];
      if (cmd.do_insert) begin
        if (!gt_prev) begin
          pay_nxt[i] = up_pay;
          pri_nxt[i] = up_pri;
        end else if (!gt[i]) begin
          pay_nxt[i] = new_pay;
          pri_nxt[i] = new_pri;
        end
      end else if (cmd.do_remove) begin
        pay_nxt[i] = dn_pay;
        pri_nxt[i] = dn_pri;
      end
    end
  end

  always_ff @(posedge clk) begin
    pay_r <= pay_nxt;
    pri_r <= pri_nxt;
  end

  // Entry count
  always_comb begin
    count_nxt = count_r;
    if (cmd.do_insert) count_nxt = CNT_W'(count_r + 1'b1);
    else if (cmd.do_remove) count_nxt = CNT_W'(count_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Result register
  assign res_pay_nxt = cmd.do_remove ? OUT_PAY_W'(pay_r[0]) : '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_pay_r    <= res_pay_nxt;
      res_status_r <= cmd.status;
      res_occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_removed_payload = res_pay_r;
  assign out_status          = res_status_r;
  assign out_occupancy       = res_occ_r;

  // Count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // An insert grows the queue by one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_insert |=> count_r == CNT_W'($past(count_r) + 1'b1))
    else $error("insert did not grow the queue");

  // Valid cells stay in descending priority order
  for (genvar i = 0; i < DEPTH - 1; i++) begin : g_order_chk
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      (CNT_W'(i + 1) < count_r) |-> (pri_r[i] >= pri_r[i+1]))
      else $error("cell row out of priority order");
  end

endmodule

// File: hw/rtl/sorted_priority_queue.sv
// Sorted priority queue top level: controller plus compare-and-shift cell row.
// An accepted word's result word appears in the output register in the next cycle.
// Throughput: one word per cycle while the input is not stalled; the cell row updates all cells in parallel.
// The input stalls only while a result is held and the output side stalls.
// Reset (synchronous, rst_n low) empties the queue and drops any held result.
// Depends on spq_pkg, spq_ctrl, spq_datapath.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_action,
  input  logic [IN_PAY_W-1:0]        in_payload,
  input  logic signed [IN_PRI_W-1:0] in_priority_req,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [OUT_PAY_W-1:0]       out_removed_payload,
  output logic [STATUS_W-1:0]        out_status,
  output logic [OCC_W-1:0]           out_occupancy
);

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  spq_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_payload          (in_payload),
    .in_priority_req     (in_priority_req),
    .stat                (stat),
    .out_removed_payload (out_removed_payload),
    .out_status          (out_status),
    .out_occupancy       (out_occupancy)
  );

endmodule
